// ===== rtl/hash_then_modexp_signer_macros.svh =====
// Assertion macros for the hash-then-modexp signer.
`ifndef HASH_THEN_MODEXP_SIGNER_MACROS_SVH
`define HASH_THEN_MODEXP_SIGNER_MACROS_SVH
`ifndef SYNTHESIS
`define HTMS_ASSERT_IMPLY(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define HTMS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define HTMS_ASSERT_IMPLY(label, ck, rs, ante, cons)
`define HTMS_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

// ===== rtl/htms_pkg.sv =====
// Shared types and constants of the hash-then-modexp signer.
package htms_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int HASH_BITS      = 64;
  localparam int SIG_BITS       = 32;
  localparam int OPERAND_BITS   = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRIVATE_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS          = 1'b1;

  localparam int MIX_SHL  = 10;
  localparam int MIX_SHR  = 6;
  localparam int FIN_SHL1 = 3;
  localparam int FIN_SHR  = 11;
  localparam int FIN_SHL2 = 15;

  typedef logic [HASH_BITS-1:0] hash_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FIN1   = 8'b0000_0010,
    ST_FIN2   = 8'b0000_0100,
    ST_REDUCE = 8'b0000_1000,
    ST_CHECK  = 8'b0001_0000,
    ST_MULACC = 8'b0010_0000,
    ST_SQUARE = 8'b0100_0000,
    ST_OUTPUT = 8'b1000_0000
  } state_t;

  function automatic hash_t hash_mix(input hash_t h, input logic [BYTE_BITS-1:0] b);
    hash_t x;
    hash_t y;
    x = h + {{(HASH_BITS-BYTE_BITS){b[BYTE_BITS-1]}}, b};
    y = x + (x << MIX_SHL);
    return y ^ (y >> MIX_SHR);
  endfunction

  function automatic hash_t hash_fin1(input hash_t h);
    hash_t x;
    x = h + (h << FIN_SHL1);
    return x ^ (x >> FIN_SHR);
  endfunction

  function automatic hash_t hash_fin2(input hash_t h);
    return h + (h << FIN_SHL2);
  endfunction

endpackage

// ===== rtl/htms_ifs.sv =====
// Valid/ready channel interfaces for message bytes and signatures.
interface htms_in_if;
  import htms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] message_byte;
  logic                 last_byte;
  modport source (output valid, message_byte, last_byte, input ready);
  modport sink (input valid, message_byte, last_byte, output ready);
endinterface

interface htms_out_if;
  import htms_pkg::*;
  logic                valid;
  logic                ready;
  logic [HASH_BITS-1:0] hash_value;
  logic [SIG_BITS-1:0]  signature;
  modport source (output valid, hash_value, signature, input ready);
  modport sink (input valid, hash_value, signature, output ready);
endinterface

// ===== rtl/hash_then_modexp_signer.sv =====
// Top level: byte-serial one-at-a-time hash followed by a modular-exponent signature.
// Bytes not marked last: taken one per cycle, back to back.
// Last byte: finalize, reduce, then per exponent bit a check, a multiply when the bit is set and a
// square; then a check sees the exponent spent and the output loads. Reduce, multiply and square
// use the bit-serial modular multiplier; intake holds until the output loads.
// Synchronous active-high reset clears the hash, sequencer and output valid.
`include "hash_then_modexp_signer_macros.svh"
module hash_then_modexp_signer #(
  parameter int MODULUS_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [htms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [htms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  htms_in_if.sink                             msg_in,
  htms_out_if.source                          sig_out
);
  import htms_pkg::*;

  state_t                   state;
  hash_t                    running_hash;
  hash_t                    final_hash;
  hash_t                    fin2_value;
  logic [SIG_BITS-1:0]      private_exponent;
  logic [MODULUS_WIDTH-1:0] modulus;
  logic [MODULUS_WIDTH-1:0] one_mod;
  logic [MODULUS_WIDTH-1:0] power_base;
  logic [MODULUS_WIDTH-1:0] power_accumulator;
  logic [SIG_BITS-1:0]      exponent_bits_left;

  logic                     out_valid;
  hash_t                    hash_value;
  logic [SIG_BITS-1:0]      signature;

  logic                     in_xfer;
  logic                     out_xfer;
  logic                     out_load;

  logic                     mm_start;
  logic [MODULUS_WIDTH-1:0] mm_a;
  logic [OPERAND_BITS-1:0]  mm_b;
  logic                     mm_done;
  logic [MODULUS_WIDTH-1:0] mm_result;
  logic                     mm_wait;

  assign msg_in.ready       = (state == ST_IDLE);
  assign in_xfer            = msg_in.valid && msg_in.ready;
  assign out_xfer           = out_valid && sig_out.ready;
  assign out_load           = (state == ST_OUTPUT) && (!out_valid || sig_out.ready);
  assign sig_out.valid      = out_valid;
  assign sig_out.hash_value = hash_value;
  assign sig_out.signature  = signature;

  assign fin2_value = hash_fin2(running_hash);
  assign one_mod    = (modulus == MODULUS_WIDTH'(1)) ? '0 : MODULUS_WIDTH'(1);
  assign mm_wait    = (state == ST_REDUCE) || (state == ST_MULACC) || (state == ST_SQUARE);

  always_comb begin
    mm_start = 1'b0;
    mm_a     = power_base;
    mm_b     = OPERAND_BITS'(power_base);
    case (state)
      ST_FIN2: begin
        mm_start = 1'b1;
        mm_a     = one_mod;
        mm_b     = fin2_value[OPERAND_BITS-1:0];
      end
      ST_CHECK: begin
        mm_start = (exponent_bits_left != '0);
        if (exponent_bits_left[0]) begin
          mm_a = power_accumulator;
        end
      end
      ST_MULACC: begin
        mm_start = mm_done;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  htms_modmul #(
    .MODULUS_WIDTH(MODULUS_WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (modulus),
    .done   (mm_done),
    .result (mm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      private_exponent <= SIG_BITS'(1);
      modulus          <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIVATE_EXPONENT: private_exponent <= cfg_data[SIG_BITS-1:0];
        CFG_MODULUS:          modulus          <= cfg_data[MODULUS_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            running_hash <= hash_mix(running_hash, msg_in.message_byte);
            if (msg_in.last_byte) begin
              state <= ST_FIN1;
            end
          end
        end
        ST_FIN1: begin
          running_hash <= hash_fin1(running_hash);
          state        <= ST_FIN2;
        end
        ST_FIN2: begin
          running_hash <= '0;
          state        <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (mm_done) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (exponent_bits_left == '0) begin
            state <= ST_OUTPUT;
          end else if (exponent_bits_left[0]) begin
            state <= ST_MULACC;
          end else begin
            state <= ST_SQUARE;
          end
        end
        ST_MULACC: begin
          if (mm_done) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mm_done) begin
            state <= ST_CHECK;
          end
        end
        ST_OUTPUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN2) begin
      final_hash <= fin2_value;
    end
    if (state == ST_REDUCE && mm_done) begin
      power_base         <= mm_result;
      power_accumulator  <= one_mod;
      exponent_bits_left <= private_exponent;
    end
    if (state == ST_MULACC && mm_done) begin
      power_accumulator <= mm_result;
    end
    if (state == ST_SQUARE && mm_done) begin
      power_base         <= mm_result;
      exponent_bits_left <= exponent_bits_left >> 1;
    end
    if (out_load) begin
      hash_value <= final_hash;
      signature  <= (modulus == '0) ? '0 : SIG_BITS'(power_accumulator);
    end
  end

  `HTMS_ASSERT_NEXT(a_last_finalizes, clk, rst, in_xfer && msg_in.last_byte, state == ST_FIN1)
  `HTMS_ASSERT_IMPLY(a_done_while_waiting, clk, rst, mm_done, mm_wait)
  `HTMS_ASSERT_NEXT(a_exp_done_outputs, clk, rst, state == ST_CHECK && exponent_bits_left == '0, state == ST_OUTPUT)
  `HTMS_ASSERT_NEXT(a_zero_mod_sig, clk, rst, out_load && modulus == '0, out_valid && signature == '0)

endmodule

// ===== rtl/htms_modmul.sv =====
// Bit-serial interleaved modular multiplier: result = a * b mod m.
module htms_modmul #(
  parameter int MODULUS_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [MODULUS_WIDTH-1:0]           a,
  input  logic [htms_pkg::OPERAND_BITS-1:0]  b,
  input  logic [MODULUS_WIDTH-1:0]           m,
  output logic                               done,
  output logic [MODULUS_WIDTH-1:0]           result
);
  import htms_pkg::*;

  localparam int CNT_BITS = $clog2(OPERAND_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OPERAND_BITS - 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic [MODULUS_WIDTH-1:0] acc;
  logic [MODULUS_WIDTH-1:0] a_q;
  logic [MODULUS_WIDTH-1:0] m_q;
  logic [OPERAND_BITS-1:0]  b_q;

  logic [MODULUS_WIDTH:0] m_ext;
  logic [MODULUS_WIDTH:0] dbl;
  logic [MODULUS_WIDTH:0] dbl_red;
  logic [MODULUS_WIDTH:0] sum;
  logic [MODULUS_WIDTH:0] sum_red;

  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (b_q[OPERAND_BITS-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_q <= a;
      b_q <= b;
      m_q <= m;
    end else if (busy) begin
      acc <= sum_red[MODULUS_WIDTH-1:0];
      b_q <= b_q << 1;
    end
  end

  assign result = acc;

endmodule
